// ===== hdl/fstfp_pkg.sv =====
// ----------------------------------------------------------------------------
// fstfp_pkg - tick and frame pacer definitions
// Operation and event codes, register indexes and reset values shared by the
// pacer and its port checker.
// ----------------------------------------------------------------------------
package fstfp_pkg;

   localparam int OP_WIDTH        = 2;
   localparam int EVENT_WIDTH     = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int TIME_WIDTH      = 64;
   localparam int COUNT_WIDTH     = 32;
   localparam int FRACTION_WIDTH  = 17;

   localparam int SKIP_LIMIT_DEFAULT    = 3;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_START = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_POLL  = 2'd2;

   localparam logic [EVENT_WIDTH-1:0] EV_WAIT  = 2'd0;
   localparam logic [EVENT_WIDTH-1:0] EV_TICK  = 2'd1;
   localparam logic [EVENT_WIDTH-1:0] EV_FRAME = 2'd2;
   localparam logic [EVENT_WIDTH-1:0] EV_ACK   = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICK_PERIOD  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_MARGIN = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] TICK_PERIOD_RESET  = 32'd16666666;
   localparam logic [CSR_DATA_WIDTH-1:0] FRAME_PERIOD_RESET = 32'd16666666;
   localparam logic [CSR_DATA_WIDTH-1:0] FRAME_MARGIN_RESET = 32'd8333333;

endpackage

// ===== hdl/fixed_step_tick_frame_pacer.sv =====
// ----------------------------------------------------------------------------
// fixed_step_tick_frame_pacer - fixed timestep tick and frame pacer
// Decides per poll whether to wait, run a simulation tick or render a
// frame, with the interpolation fraction and game time for frames.
//
// Usage:
//   req_* carries one operation (clear, start, poll) with the current time.
//   rsp_* returns exactly one event per request, in order.
//   csr_* writes tick_period, frame_period and frame_margin; write only
//   while idle.
// Timing:
//   All time arithmetic runs through one 66-bit add/subtract unit under a state
//   sequencer; one 32-bit multiplier serves the frame interpolation.
//   Clear and start go straight to the response stage; a poll steps through the
//   sequencer states, and a frame runs its divider at one divider bit per cycle.
//   req_stall is high while a request is being worked on.
// Reset: timing state cleared, registers take their default values, no
//   response pending.
// Back-pressure: a finished event is held in the response register while
//   rsp_stall is high; the next request may be taken and worked on meanwhile
//   and then waits for the response register to free.
// ----------------------------------------------------------------------------
module fixed_step_tick_frame_pacer #(
   parameter int SKIP_LIMIT    = fstfp_pkg::SKIP_LIMIT_DEFAULT,
   parameter int FRACTION_BITS = fstfp_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [fstfp_pkg::OP_WIDTH-1:0]         req_operation,
   input  logic [fstfp_pkg::TIME_WIDTH-1:0]       req_now_ns,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [fstfp_pkg::EVENT_WIDTH-1:0]      rsp_event_kind,
   output logic [fstfp_pkg::TIME_WIDTH-1:0]       rsp_wait_ns,
   output logic [fstfp_pkg::COUNT_WIDTH-1:0]      rsp_ticks_done,
   output logic [fstfp_pkg::TIME_WIDTH-1:0]       rsp_tick_game_ns,
   output logic [fstfp_pkg::COUNT_WIDTH-1:0]      rsp_frames_done,
   output logic [fstfp_pkg::TIME_WIDTH-1:0]       rsp_frame_game_ns,
   output logic [fstfp_pkg::FRACTION_WIDTH-1:0]   rsp_frame_fraction,
   input  logic                                   csr_write_enable,
   input  logic [fstfp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fstfp_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   localparam int SkipW   = $clog2(SKIP_LIMIT + 1);
   localparam int FracW   = FRACTION_BITS + 1;
   localparam int CntW    = $clog2(FRACTION_BITS);
   localparam int ProdW   = 32 + FracW;
   localparam int HiShift = 32 - FRACTION_BITS;
   localparam int AluW    = fstfp_pkg::TIME_WIDTH + 2;

   localparam logic [SkipW-1:0] SkipMax  = SkipW'(SKIP_LIMIT);
   localparam logic [CntW-1:0]  CntLast  = CntW'(FRACTION_BITS - 1);
   localparam logic [FracW-1:0] FracOne  = {1'b1, {FRACTION_BITS{1'b0}}};

   typedef enum logic [4:0] {
      S_IDLE, S_NT, S_NF, S_DUE, S_NOW, S_WAIT, S_TCK1, S_TCK2, S_TGAME,
      S_TREAL, S_LATE, S_MAXF, S_FCUR, S_FNOW, S_FCMP, S_DIV, S_DIFF,
      S_MULHI, S_MULLO, S_ADDLO, S_ADDPREV, S_OUT
   } state_type;

   state_type   state_ff;

   logic [31:0] tick_period_ff, frame_period_ff, frame_margin_ff;

   logic [31:0] tick_counter_ff, frame_counter_ff;
   logic [63:0] prev_tick_game_ff, cur_tick_game_ff;
   logic [63:0] prev_tick_real_ff, cur_tick_real_ff;
   logic [63:0] frame_game_ff, frame_real_ff;
   logic [FracW-1:0] fraction_ff;
   logic [SkipW-1:0] skipped_ff;

   logic [63:0] now_ff, t0_ff, t1_ff, t2_ff, rem_ff, den_ff;
   logic [FracW-1:0] q_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [ProdW-1:0] prod_ff;
   logic [1:0]  kind_ff;
   logic [63:0] wait_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [63:0] rsp_wait_ff, rsp_tick_game_ff, rsp_frame_game_ff;
   logic [31:0] rsp_ticks_ff, rsp_frames_ff;
   logic [FracW-1:0] rsp_fraction_ff;

   logic [AluW-1:0] alu_a, alu_b, alu_sum;
   logic            alu_sub, alu_neg, alu_carry, alu_zero;
   logic [63:0]     alu_low, alu_sat;
   logic [31:0]     mul_a;
   logic [ProdW-1:0] mul_prod;
   logic            fp_zero;

   assign fp_zero = (frame_period_ff == '0);

   // shared add/subtract unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      case (state_ff)
         S_NT: begin
            alu_a = AluW'(cur_tick_real_ff); alu_b = AluW'(1); alu_sub = 1'b0;
         end
         S_NF: begin
            alu_a = AluW'(frame_real_ff); alu_b = AluW'(frame_period_ff);
            alu_sub = 1'b0;
         end
         S_DUE:   begin alu_a = AluW'(t1_ff);            alu_b = AluW'(t0_ff);  end
         S_NOW:   begin alu_a = AluW'(now_ff);           alu_b = AluW'(t0_ff);  end
         S_WAIT:  begin alu_a = AluW'(t0_ff);            alu_b = AluW'(now_ff); end
         S_TCK1:  begin alu_a = AluW'(cur_tick_real_ff); alu_b = AluW'(now_ff); end
         S_TCK2:  begin alu_a = AluW'(frame_real_ff);    alu_b = AluW'(now_ff); end
         S_TGAME: begin
            alu_a = AluW'(cur_tick_game_ff); alu_b = AluW'(tick_period_ff);
            alu_sub = 1'b0;
         end
         S_TREAL: begin
            alu_a = AluW'(cur_tick_real_ff); alu_b = AluW'(tick_period_ff);
            alu_sub = 1'b0;
         end
         S_LATE:  begin alu_a = AluW'(now_ff); alu_b = AluW'(frame_margin_ff); end
         S_MAXF:  begin alu_a = AluW'(t1_ff);  alu_b = AluW'(t2_ff); end
         S_FCUR:  begin
            alu_a = AluW'(cur_tick_real_ff); alu_b = AluW'(prev_tick_real_ff);
         end
         S_FNOW:  begin alu_a = AluW'(now_ff); alu_b = AluW'(prev_tick_real_ff); end
         S_FCMP:  begin alu_a = AluW'(rem_ff); alu_b = AluW'(den_ff); end
         S_DIV:   begin alu_a = {1'b0, rem_ff, 1'b0}; alu_b = AluW'(den_ff); end
         S_DIFF:  begin
            alu_a = AluW'(cur_tick_game_ff); alu_b = AluW'(prev_tick_game_ff);
         end
         S_ADDLO: begin
            alu_a = AluW'(t0_ff); alu_b = AluW'(prod_ff >> FRACTION_BITS);
            alu_sub = 1'b0;
         end
         S_ADDPREV: begin
            alu_a = AluW'(t0_ff); alu_b = AluW'(prev_tick_game_ff); alu_sub = 1'b0;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_sum   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_neg   = alu_sum[AluW-1];
   assign alu_carry = alu_sum[64];
   assign alu_low   = alu_sum[63:0];
   assign alu_zero  = (alu_low == '0);
   assign alu_sat   = alu_carry ? '1 : alu_low;

   assign mul_a    = (state_ff == S_MULHI) ? t2_ff[63:32] : t2_ff[31:0];
   assign mul_prod = ProdW'(mul_a) * ProdW'(q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         tick_period_ff    <= fstfp_pkg::TICK_PERIOD_RESET;
         frame_period_ff   <= fstfp_pkg::FRAME_PERIOD_RESET;
         frame_margin_ff   <= fstfp_pkg::FRAME_MARGIN_RESET;
         tick_counter_ff   <= '0;
         frame_counter_ff  <= '0;
         prev_tick_game_ff <= '0;
         cur_tick_game_ff  <= '0;
         prev_tick_real_ff <= '0;
         cur_tick_real_ff  <= '0;
         frame_game_ff     <= '0;
         frame_real_ff     <= '0;
         fraction_ff       <= '0;
         skipped_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               fstfp_pkg::CSR_TICK_PERIOD:  tick_period_ff  <= csr_write_data;
               fstfp_pkg::CSR_FRAME_PERIOD: frame_period_ff <= csr_write_data;
               fstfp_pkg::CSR_FRAME_MARGIN: frame_margin_ff <= csr_write_data;
               default: ;
            endcase
         end

         // in S_OUT the response register is reloaded below instead
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  now_ff  <= req_now_ns;
                  wait_ff <= '0;
                  kind_ff <= fstfp_pkg::EV_ACK;
                  case (req_operation)
                     fstfp_pkg::OP_CLEAR: begin
                        prev_tick_game_ff <= '0;
                        cur_tick_game_ff  <= '0;
                        prev_tick_real_ff <= '0;
                        cur_tick_real_ff  <= '0;
                        frame_counter_ff  <= '0;
                        frame_game_ff     <= '0;
                        frame_real_ff     <= '0;
                        skipped_ff        <= '0;
                        state_ff          <= S_OUT;
                     end
                     fstfp_pkg::OP_START: begin
                        tick_counter_ff   <= '0;
                        prev_tick_real_ff <= '0;
                        cur_tick_real_ff  <= req_now_ns;
                        frame_real_ff     <= '0;
                        skipped_ff        <= '0;
                        state_ff          <= S_OUT;
                     end
                     fstfp_pkg::OP_POLL: begin
                        state_ff <= S_NT;
                     end
                     default: begin
                        state_ff <= S_OUT;
                     end
                  endcase
               end
            end
            S_NT: begin
               t0_ff    <= alu_sat;
               state_ff <= S_NF;
            end
            S_NF: begin
               t1_ff    <= alu_sat;
               state_ff <= S_DUE;
            end
            S_DUE: begin
               if (!fp_zero && alu_neg) begin
                  t0_ff <= t1_ff;
               end
               state_ff <= S_NOW;
            end
            S_NOW: begin
               if (alu_neg) begin
                  if (fp_zero) begin
                     kind_ff  <= fstfp_pkg::EV_FRAME;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_WAIT;
                  end
               end else if (skipped_ff < SkipMax) begin
                  state_ff <= S_TCK1;
               end else begin
                  state_ff <= S_LATE;
               end
            end
            S_WAIT: begin
               wait_ff  <= alu_low;
               kind_ff  <= fstfp_pkg::EV_WAIT;
               state_ff <= S_OUT;
            end
            S_TCK1: begin
               state_ff <= alu_neg ? S_TCK2 : S_LATE;
            end
            S_TCK2: begin
               if (alu_neg) begin
                  skipped_ff <= skipped_ff + SkipW'(1);
               end
               tick_counter_ff <= tick_counter_ff + 32'd1;
               state_ff        <= S_TGAME;
            end
            S_TGAME: begin
               prev_tick_game_ff <= cur_tick_game_ff;
               cur_tick_game_ff  <= alu_low;
               state_ff          <= S_TREAL;
            end
            S_TREAL: begin
               prev_tick_real_ff <= cur_tick_real_ff;
               cur_tick_real_ff  <= alu_sat;
               kind_ff           <= fstfp_pkg::EV_TICK;
               state_ff          <= S_OUT;
            end
            S_LATE: begin
               t2_ff    <= alu_neg ? '0 : alu_low;
               state_ff <= S_MAXF;
            end
            S_MAXF: begin
               frame_real_ff    <= alu_neg ? t2_ff : t1_ff;
               frame_counter_ff <= frame_counter_ff + 32'd1;
               skipped_ff       <= '0;
               state_ff         <= S_FCUR;
            end
            S_FCUR: begin
               if (alu_neg || alu_zero) begin
                  q_ff     <= FracOne;
                  state_ff <= S_DIFF;
               end else begin
                  den_ff   <= alu_low;
                  state_ff <= S_FNOW;
               end
            end
            S_FNOW: begin
               if (alu_neg || alu_zero) begin
                  q_ff     <= '0;
                  state_ff <= S_DIFF;
               end else begin
                  rem_ff   <= alu_low;
                  state_ff <= S_FCMP;
               end
            end
            S_FCMP: begin
               if (!alu_neg) begin
                  q_ff     <= FracOne;
                  state_ff <= S_DIFF;
               end else begin
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!alu_neg) begin
                  rem_ff <= alu_low;
                  q_ff   <= {q_ff[FRACTION_BITS-1:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[62:0], 1'b0};
                  q_ff   <= {q_ff[FRACTION_BITS-1:0], 1'b0};
               end
               cnt_ff <= cnt_ff + CntW'(1);
               if (cnt_ff == CntLast) begin
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: begin
               fraction_ff <= q_ff;
               t2_ff       <= alu_low;
               state_ff    <= S_MULHI;
            end
            S_MULHI: begin
               prod_ff  <= mul_prod;
               state_ff <= S_MULLO;
            end
            S_MULLO: begin
               t0_ff    <= 64'(prod_ff) << HiShift;
               prod_ff  <= mul_prod;
               state_ff <= S_ADDLO;
            end
            S_ADDLO: begin
               t0_ff    <= alu_low;
               state_ff <= S_ADDPREV;
            end
            S_ADDPREV: begin
               frame_game_ff <= alu_low;
               kind_ff       <= fstfp_pkg::EV_FRAME;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_kind_ff       <= kind_ff;
                  rsp_wait_ff       <= wait_ff;
                  rsp_ticks_ff      <= tick_counter_ff;
                  rsp_tick_game_ff  <= cur_tick_game_ff;
                  rsp_frames_ff     <= frame_counter_ff;
                  rsp_frame_game_ff <= frame_game_ff;
                  rsp_fraction_ff   <= fraction_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_kind_ff;
   assign rsp_wait_ns        = rsp_wait_ff;
   assign rsp_ticks_done     = rsp_ticks_ff;
   assign rsp_tick_game_ns   = rsp_tick_game_ff;
   assign rsp_frames_done    = rsp_frames_ff;
   assign rsp_frame_game_ns  = rsp_frame_game_ff;
   assign rsp_frame_fraction = fstfp_pkg::FRACTION_WIDTH'(rsp_fraction_ff);

endmodule

// ===== hdl/fstfp_checker.sv =====
// ----------------------------------------------------------------------------
// fstfp_checker - port checks for the tick and frame pacer
// Watches the response channel over time; bound to the top level below.
// ----------------------------------------------------------------------------
module fstfp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [fstfp_pkg::EVENT_WIDTH-1:0]    rsp_event_kind,
   input logic [fstfp_pkg::TIME_WIDTH-1:0]     rsp_wait_ns,
   input logic [fstfp_pkg::COUNT_WIDTH-1:0]    rsp_ticks_done
);

   // a stalled transfer holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_wait_ns) && $stable(rsp_ticks_done))
      else $error("stalled response changed");

   // no response is pending straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a wait always reports time still to go
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == fstfp_pkg::EV_WAIT) |-> rsp_wait_ns != '0)
      else $error("wait event with zero wait time");

   // only a wait carries a wait time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != fstfp_pkg::EV_WAIT) |-> rsp_wait_ns == '0)
      else $error("wait time on a non-wait event");

endmodule

bind fixed_step_tick_frame_pacer fstfp_checker u_fstfp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_kind (rsp_event_kind),
   .rsp_wait_ns    (rsp_wait_ns),
   .rsp_ticks_done (rsp_ticks_done)
);
